@@ rtl/wss_pkg.sv @@
package wss_pkg;

    localparam int TIME_W = 40;
    localparam int AMT_W  = 48;
    localparam int SUM_W  = 50;

    localparam logic [1:0] CMD_CLEAR  = 2'd0;
    localparam logic [1:0] CMD_LOAD   = 2'd1;
    localparam logic [1:0] CMD_QUERY  = 2'd2;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam logic [1:0] CFG_MODE = 2'd0;
    localparam logic [1:0] CFG_TOL  = 2'd1;
    localparam logic [1:0] CFG_HOR  = 2'd2;
    localparam logic [1:0] CFG_NONE = 2'd3;

    typedef struct packed {
        logic [1:0]        cmd;
        logic [TIME_W-1:0] event_time;
        logic [AMT_W-1:0]  amount;
    } in_item_t;

    typedef struct packed {
        logic [5:0] withdrawal_index;
        logic [2:0] support;
        logic       last;
    } out_item_t;

endpackage

@@ rtl/withdrawal_sum_support.sv @@
// A load or clear is taken while idle. A query over n stored withdrawals first
// marks the eligible entries, then checks each eligible pair and walks the triple
// candidates for it, then emits n results. The input stalls for a whole query;
// results leave one per cycle, while out_stall is low, through an output register.
// Reset (rst_n low, asynchronous): empties the table, mode 0, tolerance 0, horizon
// all ones. Memory contents are not cleared.
module withdrawal_sum_support #(
    parameter int MAX_WITHDRAWALS = 64
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  wss_pkg::in_item_t         in_data,
    output logic                      out_valid,
    input  logic                      out_stall,
    output wss_pkg::out_item_t        out_data,
    input  logic                      cfg_we,
    input  logic [1:0]                cfg_index,
    input  logic [47:0]               cfg_data
);
    import wss_pkg::*;

    localparam int IW = (MAX_WITHDRAWALS > 1) ? $clog2(MAX_WITHDRAWALS) : 1;
    localparam int CW = $clog2(MAX_WITHDRAWALS + 1);

    typedef enum logic [2:0] {
        S_IDLE, S_ELIG, S_PAIR, S_TRIP, S_EMIT
    } state_t;

    logic [TIME_W-1:0] time_mem [MAX_WITHDRAWALS];
    logic [AMT_W-1:0]  amt_mem  [MAX_WITHDRAWALS];

    state_t            state_reg;
    logic              mode_reg;
    logic [AMT_W-1:0]  tol_reg;
    logic [TIME_W-1:0] hor_reg;
    logic [CW-1:0]     count_reg;
    logic [TIME_W-1:0] qt_reg;
    logic [AMT_W-1:0]  qd_reg;
    logic [MAX_WITHDRAWALS-1:0] elig_reg;
    logic [MAX_WITHDRAWALS-1:0] s1_reg, s2_reg, s3_reg;
    logic [CW-1:0]     a_reg, b_reg, c_reg;
    logic              rvalid_reg;
    logic [IW-1:0]     ra_reg, rc_reg;
    logic [TIME_W-1:0] rt_reg;
    logic [AMT_W-1:0]  rd_reg;
    logic [AMT_W-1:0]  va_reg;
    logic [SUM_W-1:0]  vab_reg;
    logic [CW-1:0]     e_reg;
    logic              ov_reg;
    out_item_t         od_reg;

    // read address driven by state; fetch a before its pair walk starts
    logic [IW-1:0] raddr;
    always_comb
    begin
        case (state_reg)
            S_ELIG:  raddr = a_reg[IW-1:0];
            S_PAIR:  raddr = rvalid_reg ? b_reg[IW-1:0] : a_reg[IW-1:0];
            S_TRIP:  raddr = c_reg[IW-1:0];
            default: raddr = '0;
        endcase
    end

    function automatic logic near(input logic [SUM_W-1:0] s, input logic [AMT_W-1:0] d,
                                  input logic [AMT_W-1:0] t);
        logic [SUM_W-1:0] hi, lo;
        hi = {2'b0, d} + {2'b0, t};
        lo = s + {2'b0, t};
        return (s <= hi) && (lo >= {2'b0, d});
    endfunction

    logic [TIME_W-1:0] dt;
    logic [SUM_W-1:0]  s3;
    logic              ok;
    logic              emit_go;
    assign dt = rt_reg - qt_reg;
    assign s3 = vab_reg + {2'b0, rd_reg};
    assign ok = (rt_reg > qt_reg) && !(mode_reg && dt > hor_reg)
                && ({1'b0, rd_reg} <= {1'b0, qd_reg} + {1'b0, tol_reg});
    assign emit_go = (state_reg == S_EMIT) && (!ov_reg || !out_stall);

    assign in_stall = (state_reg != S_IDLE);
    assign out_valid = ov_reg;
    assign out_data  = od_reg;

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_valid && in_data.cmd == CMD_LOAD
            && count_reg < CW'(MAX_WITHDRAWALS))
        begin
            time_mem[count_reg[IW-1:0]] <= in_data.event_time;
            amt_mem[count_reg[IW-1:0]]  <= in_data.amount;
        end
        rt_reg <= time_mem[raddr];
        rd_reg <= amt_mem[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            mode_reg   <= 1'b0;
            tol_reg    <= '0;
            hor_reg    <= '1;
            count_reg  <= '0;
            ov_reg     <= 1'b0;
            rvalid_reg <= 1'b0;
            a_reg <= '0; b_reg <= '0; c_reg <= '0; e_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_MODE: mode_reg <= cfg_data[0];
                    CFG_TOL:  tol_reg  <= cfg_data;
                    CFG_HOR:  hor_reg  <= cfg_data[TIME_W-1:0];
                    default:  ;
                endcase
            end
            if (emit_go)
                ov_reg <= 1'b1;
            else if (!out_stall)
                ov_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    rvalid_reg <= 1'b0;
                    if (in_valid)
                    begin
                        case (in_data.cmd)
                            CMD_CLEAR: count_reg <= '0;
                            CMD_LOAD:
                                if (count_reg < CW'(MAX_WITHDRAWALS))
                                    count_reg <= count_reg + 1'b1;
                            CMD_QUERY:
                                if (count_reg != '0)
                                begin
                                    qt_reg   <= in_data.event_time;
                                    qd_reg   <= in_data.amount;
                                    elig_reg <= '0;
                                    s1_reg <= '0; s2_reg <= '0; s3_reg <= '0;
                                    a_reg    <= '0;
                                    state_reg <= S_ELIG;
                                end
                            default: ;
                        endcase
                    end
                end
                // stream all entries, mark eligible ones and size-1 hits
                S_ELIG:
                begin
                    ra_reg <= a_reg[IW-1:0];
                    if (rvalid_reg)
                    begin
                        elig_reg[ra_reg] <= ok;
                        if (ok && near({2'b0, rd_reg}, qd_reg, tol_reg))
                            s1_reg[ra_reg] <= 1'b1;
                    end
                    if (a_reg < count_reg)
                    begin
                        a_reg <= a_reg + 1'b1;
                        rvalid_reg <= 1'b1;
                    end
                    else if (rvalid_reg)
                        rvalid_reg <= 1'b0;
                    else
                    begin
                        a_reg <= '0; b_reg <= '0;
                        state_reg <= S_PAIR;
                    end
                end
                // fix a, read b; after the pair check, walk c for triples
                S_PAIR:
                begin
                    if (a_reg >= count_reg)
                    begin
                        e_reg <= '0;
                        state_reg <= S_EMIT;
                    end
                    else if (!elig_reg[a_reg[IW-1:0]])
                        a_reg <= a_reg + 1'b1;
                    else if (!rvalid_reg)
                    begin
                        // fetch va first through b = a
                        b_reg <= a_reg;
                        rvalid_reg <= 1'b1;
                        ra_reg <= a_reg[IW-1:0];
                    end
                    else if (rvalid_reg && ra_reg == a_reg[IW-1:0] && b_reg == a_reg)
                    begin
                        va_reg <= rd_reg;
                        b_reg  <= a_reg + 1'b1;
                        ra_reg <= '1;
                        rvalid_reg <= 1'b1;
                        c_reg <= '0;
                    end
                    else
                    begin
                        if (b_reg >= count_reg)
                        begin
                            a_reg <= a_reg + 1'b1;
                            rvalid_reg <= 1'b0;
                        end
                        else if (!elig_reg[b_reg[IW-1:0]])
                            b_reg <= b_reg + 1'b1;
                        else if (c_reg != b_reg + 1'b1)
                        begin
                            // let the b read return before the pair check
                            c_reg <= b_reg + 1'b1;
                        end
                        else
                        begin
                            vab_reg <= {2'b0, va_reg} + {2'b0, rd_reg};
                            if (near({2'b0, va_reg} + {2'b0, rd_reg}, qd_reg, tol_reg))
                            begin
                                s2_reg[a_reg[IW-1:0]] <= 1'b1;
                                s2_reg[b_reg[IW-1:0]] <= 1'b1;
                            end
                            rvalid_reg <= 1'b0;
                            state_reg <= S_TRIP;
                        end
                    end
                end
                S_TRIP:
                begin
                    rc_reg <= c_reg[IW-1:0];
                    if (rvalid_reg && near(s3, qd_reg, tol_reg))
                    begin
                        s3_reg[a_reg[IW-1:0]] <= 1'b1;
                        s3_reg[b_reg[IW-1:0]] <= 1'b1;
                        s3_reg[rc_reg] <= 1'b1;
                    end
                    if (c_reg < count_reg)
                    begin
                        rvalid_reg <= elig_reg[c_reg[IW-1:0]];
                        c_reg <= c_reg + 1'b1;
                    end
                    else if (rvalid_reg)
                        rvalid_reg <= 1'b0;
                    else
                    begin
                        b_reg <= b_reg + 1'b1;
                        c_reg <= '0;
                        state_reg <= S_PAIR;
                        rvalid_reg <= 1'b1;
                        ra_reg <= '1;
                    end
                end
                S_EMIT:
                begin
                    if (emit_go)
                    begin
                        od_reg.withdrawal_index <= 6'(e_reg);
                        od_reg.last <= (e_reg + 1'b1 == count_reg);
                        if (mode_reg)
                            od_reg.support <= {s3_reg[e_reg[IW-1:0]],
                                s2_reg[e_reg[IW-1:0]], s1_reg[e_reg[IW-1:0]]};
                        else if (s1_reg[e_reg[IW-1:0]])
                            od_reg.support <= 3'd1;
                        else if (s2_reg[e_reg[IW-1:0]])
                            od_reg.support <= 3'd2;
                        else if (s3_reg[e_reg[IW-1:0]])
                            od_reg.support <= 3'd3;
                        else
                            od_reg.support <= 3'd0;
                        e_reg <= e_reg + 1'b1;
                        if (e_reg + 1'b1 == count_reg)
                            state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

@@ tb/wss_checker.sv @@
`timescale 1ns / 1ps

module wss_checker #(
    parameter int MAX_WITHDRAWALS = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  wss_pkg::in_item_t  in_data,
    input  logic               out_valid,
    input  logic               out_stall,
    input  wss_pkg::out_item_t out_data,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [47:0]        cfg_data,
    output int                 fail_count,
    output int                 pending
);
    import wss_pkg::*;

    logic               mode_q;
    logic [AMT_W-1:0]   tol_q;
    logic [TIME_W-1:0]  hor_q;
    logic [TIME_W-1:0]  w_time [MAX_WITHDRAWALS];
    logic [AMT_W-1:0]   w_amt  [MAX_WITHDRAWALS];
    int                 w_count;
    out_item_t          expected_support [$];

    function automatic logic near(logic [63:0] s, logic [63:0] d);
        return (s <= d + 64'(tol_q)) && (s + 64'(tol_q) >= d);
    endfunction

    // compute the support of every stored withdrawal for one deposit
    task automatic predict_query(logic [TIME_W-1:0] t, logic [AMT_W-1:0] d);
        int        elig [$];
        logic [2:0] sup [MAX_WITHDRAWALS];
        logic [63:0] va, vab;
        logic [2:0] s;
        out_item_t  r;
        for (int i = 0; i < w_count; i++)
        begin
            sup[i] = '0;
            if (w_time[i] <= t) continue;
            if (mode_q && (w_time[i] - t > hor_q)) continue;
            if (64'(w_amt[i]) > 64'(d) + 64'(tol_q)) continue;
            elig = {elig, i};
        end
        for (int a = 0; a < elig.size(); a++)
        begin
            va = 64'(w_amt[elig[a]]);
            if (near(va, 64'(d))) sup[elig[a]] |= 3'b001;
            for (int b = a + 1; b < elig.size(); b++)
            begin
                vab = va + 64'(w_amt[elig[b]]);
                if (near(vab, 64'(d)))
                begin
                    sup[elig[a]] |= 3'b010;
                    sup[elig[b]] |= 3'b010;
                end
                for (int c = b + 1; c < elig.size(); c++)
                    if (near(vab + 64'(w_amt[elig[c]]), 64'(d)))
                    begin
                        sup[elig[a]] |= 3'b100;
                        sup[elig[b]] |= 3'b100;
                        sup[elig[c]] |= 3'b100;
                    end
            end
        end
        for (int i = 0; i < w_count; i++)
        begin
            s = sup[i];
            if (!mode_q)
                s = s[0] ? 3'd1 : s[1] ? 3'd2 : s[2] ? 3'd3 : 3'd0;
            r.withdrawal_index = 6'(i);
            r.support = s;
            r.last = (i + 1 == w_count);
            expected_support = {expected_support, r};
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        out_item_t e;
        if (!rst_n)
        begin
            mode_q <= 1'b0;
            tol_q <= '0;
            hor_q <= '1;
            w_count = 0;
            fail_count <= 0;
            pending <= 0;
            expected_support.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_MODE: mode_q <= cfg_data[0];
                    CFG_TOL:  tol_q <= cfg_data;
                    CFG_HOR:  hor_q <= cfg_data[TIME_W-1:0];
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
            begin
                case (in_data.cmd)
                    CMD_CLEAR: w_count = 0;
                    CMD_LOAD:
                        if (w_count < MAX_WITHDRAWALS)
                        begin
                            w_time[w_count] = in_data.event_time;
                            w_amt[w_count] = in_data.amount;
                            w_count++;
                        end
                    CMD_QUERY: predict_query(in_data.event_time, in_data.amount);
                    default: ;
                endcase
            end
            if (out_valid && !out_stall)
            begin
                if (expected_support.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("unexpected beat: idx %0d sup %0d last %0d",
                                 out_data.withdrawal_index, out_data.support, out_data.last);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    e = expected_support.pop_front();
                    if (out_data !== e)
                    begin
                        if (fail_count < 10)
                            $display("beat mismatch: exp idx %0d sup %0d last %0d, ",
                                     e.withdrawal_index, e.support, e.last,
                                     "got idx %0d sup %0d last %0d",
                                     out_data.withdrawal_index, out_data.support,
                                     out_data.last);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            pending <= expected_support.size();
        end
    end

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
    import wss_pkg::*;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    in_item_t   in_data = '0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    out_item_t  out_data;
    logic       cfg_we = 1'b0;
    logic [1:0] cfg_index = '0;
    logic [47:0] cfg_data = '0;
    int         fail_count;
    int         pending;
    int         send_idle_pct = 0;
    int         recv_idle_pct = 0;
    int         hold_off = 0;
    logic       hold_go = 1'b0;
    logic       hold_used = 1'b0;
    longint     cycle_count = 0;
    logic [TIME_W-1:0] base_time;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    withdrawal_sum_support DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    wss_checker checker_i (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .fail_count(fail_count), .pending(pending)
    );

    // receiver: random stall, plus one long hold-off when asked
    always @(posedge clk)
    begin
        if (hold_go && !hold_used)
        begin
            hold_used <= 1'b1;
            hold_off <= 400;
            out_stall <= 1'b1;
        end
        else if (hold_off > 0)
        begin
            out_stall <= 1'b1;
            hold_off <= hold_off - 1;
        end
        else
            out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 3000000)
        begin
            $display("withdrawal_sum_support: mismatch");
            $finish;
        end
    end

    task automatic send_beat(logic [1:0] cmd, logic [TIME_W-1:0] t, logic [AMT_W-1:0] a);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= '{cmd: cmd, event_time: t, amount: a};
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [47:0] v);
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (50) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // table of n withdrawals around base time, then a query at base time; some amounts built to sum to d
    task automatic fill_and_query(int n, logic [AMT_W-1:0] d);
        logic [AMT_W-1:0] part;
        logic [AMT_W-1:0] amt;
        send_beat(CMD_CLEAR, '0, '0);
        for (int i = 0; i < n; i++)
        begin
            part = AMT_W'($urandom_range(1, 1000));
            case ($urandom_range(3))
                0: amt = d;
                1: amt = d / 2 + AMT_W'($urandom_range(1));
                2: amt = d / 3 + AMT_W'($urandom_range(2));
                default: amt = part;
            endcase
            send_beat(CMD_LOAD, base_time + TIME_W'($urandom_range(0, 200000)) - 40'd20000,
                      amt);
        end
        if ($urandom_range(3) == 0)
            send_beat(CMD_UNUSED, TIME_W'({$urandom, $urandom}),
                      AMT_W'({$urandom, $urandom}));
        send_beat(CMD_QUERY, base_time, d);
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        base_time = 40'd100000;

        // directed: empty table, extremes, exact singles, pairs and triples
        send_beat(CMD_QUERY, '0, '0);
        send_beat(CMD_LOAD, '1, '1);
        send_beat(CMD_LOAD, '1, 48'd0);
        send_beat(CMD_LOAD, 40'd5, 48'd10);
        send_beat(CMD_LOAD, 40'd6, 48'd20);
        send_beat(CMD_LOAD, 40'd7, 48'd30);
        send_beat(CMD_LOAD, 40'd3, 48'd60);
        send_beat(CMD_QUERY, 40'd4, 48'd60);
        send_beat(CMD_QUERY, '0, '1);
        send_beat(CMD_QUERY, '1, 48'd10);
        send_beat(CMD_UNUSED, '1, '1);
        write_reg(CFG_TOL, '1);
        send_beat(CMD_QUERY, '0, '1);
        send_beat(CMD_QUERY, 40'd4, 48'd0);
        write_reg(CFG_MODE, 48'd1);
        write_reg(CFG_HOR, 48'd2);
        write_reg(CFG_TOL, 48'd0);
        send_beat(CMD_QUERY, 40'd4, 48'd30);
        write_reg(CFG_HOR, 48'hFF_FFFF_FFFF);
        send_beat(CMD_QUERY, 40'd4, 48'd60);
        write_reg(CFG_NONE, 48'd5);
        // fill past capacity; extra loads are dropped
        send_beat(CMD_CLEAR, '0, '0);
        for (int i = 0; i < 66; i++)
            send_beat(CMD_LOAD, 40'd1000 + 40'(i), AMT_W'(i + 1));
        write_reg(CFG_MODE, 48'd0);
        send_beat(CMD_QUERY, 40'd999, 48'd6);

        // random: three phases with varied idle rates and settings
        for (int ph = 0; ph < 3; ph++)
        begin
            send_idle_pct = (ph == 0) ? 27 : (ph == 1) ? 77 : 0;
            recv_idle_pct = (ph == 0) ? 77 : (ph == 1) ? 27 : 0;
            write_reg(CFG_MODE, 48'($urandom_range(1)));
            write_reg(CFG_TOL, 48'($urandom_range(0, 3)));
            write_reg(CFG_HOR, (ph == 1) ? 48'd60000 : 48'hFF_FFFF_FFFF);
            for (int q = 0; q < 2; q++)
            begin
                if (ph == 0 && q == 1) hold_go <= 1'b1;
                fill_and_query($urandom_range(3, 10), AMT_W'($urandom_range(30, 3000)));
            end
            if (ph == 2)
            begin
                // random-bit noise to toggle every field bit
                for (int k = 0; k < 6; k++)
                    send_beat(CMD_LOAD, TIME_W'({$urandom, $urandom}),
                              AMT_W'({$urandom, $urandom}));
                send_beat(CMD_QUERY, TIME_W'({$urandom, $urandom}),
                          AMT_W'({$urandom, $urandom}));
                send_beat(CMD_QUERY, '0, AMT_W'({$urandom, $urandom}));
            end
        end

        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (100) @(posedge clk);
        if (fail_count == 0)
            $display("withdrawal_sum_support: match");
        else
            $display("withdrawal_sum_support: mismatch");
        $finish;
    end

endmodule
